/* rtl/vps_pkg.sv */
`timescale 1ns / 1ps

package vps_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FEW      = 2'd1;
    localparam logic [1:0] ST_ORDER    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_WDATA  = 2'd0;
    localparam logic [1:0] REG_WSMOOTH = 2'd1;
    localparam logic [1:0] REG_MAXIT  = 2'd2;
    localparam logic [1:0] REG_THRESH = 2'd3;

    localparam logic [15:0] DEFAULT_SWEEPS    = 16'd100;
    localparam logic [30:0] DEFAULT_THRESHOLD = 31'd655;

    // Operation codes for the shared update unit
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_FIT  = 2'd1,
        OP_SMO  = 2'd2,
        OP_SUM  = 2'd3
    } alu_op_t;

    // Command from sequencer to update unit
    typedef struct packed {
        logic    en;
        alu_op_t op;
    } alu_cmd_t;

endpackage

/* rtl/vps_alu.sv */
`timescale 1ns / 1ps

// Shared update unit: one multiply per step, accumulating one point update.
module vps_alu
(
    input  logic               clk,
    input  vps_pkg::alu_cmd_t  cmd,
    input  logic signed [31:0] v_left,
    input  logic signed [31:0] v_mid,
    input  logic signed [31:0] v_right,
    input  logic signed [31:0] v_ref,
    input  logic        [15:0] wd,
    input  logic        [15:0] ws,
    output logic signed [31:0] new_v,
    output logic        [31:0] change
);

    logic signed [33:0] opnd_reg;
    logic signed [33:0] opnd_next;
    logic signed [16:0] wgt;
    logic signed [51:0] prod;
    logic signed [51:0] rnd_in;
    logic signed [35:0] term;
    logic signed [35:0] acc_reg;
    logic signed [35:0] acc_next;
    logic signed [35:0] sum;
    logic signed [32:0] diff;

    // Operand and weight for the current multiply step
    always_comb
    begin
        opnd_next = opnd_reg;
        wgt       = 17'sd0;
        acc_next  = acc_reg;
        unique case (cmd.op)
            vps_pkg::OP_LOAD:
            begin
                opnd_next = 34'(v_ref) - 34'(v_mid);
                acc_next  = 36'(v_mid);
            end
            vps_pkg::OP_FIT:
            begin
                wgt       = $signed({1'b0, wd});
                opnd_next = 34'(v_left) + 34'(v_right) - (34'(v_mid) <<< 1);
            end
            vps_pkg::OP_SMO:
            begin
                wgt = $signed({1'b0, ws});
            end
            vps_pkg::OP_SUM:
            begin
            end
            default:
            begin
            end
        endcase
        if (cmd.op == vps_pkg::OP_FIT || cmd.op == vps_pkg::OP_SMO)
        begin
            acc_next = acc_reg + term;
        end
    end

    // Product rounded to Q16.16: add half, floor shift
    assign prod   = 52'(opnd_reg) * 52'(wgt);
    assign rnd_in = prod + 52'sd32768;
    assign term   = 36'(rnd_in >>> 16);

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            opnd_reg <= opnd_next;
            acc_reg  <= acc_next;
        end
    end

    // Saturate the accumulated value and form the change magnitude
    assign sum = acc_reg;
    always_comb
    begin
        if (sum > 36'sd2147483647)
        begin
            new_v = 32'sh7FFFFFFF;
        end
        else if (sum < -36'sd2147483648)
        begin
            new_v = 32'sh80000000;
        end
        else
        begin
            new_v = sum[31:0];
        end
        diff   = 33'(new_v) - 33'(v_mid);
        change = diff[32] ? 32'(-diff) : diff[31:0];
    end

endmodule

/* rtl/velocity_profile_smoother.sv */
`timescale 1ns / 1ps

// Points load at one per cycle while start is high and busy is low.
// After a valid last point each sweep steps through every interior point in turn (three reads, a wait,
// three passes through the shared multiply unit and a write) and then one check state.
// Busy then lasts through the sweeps and the output, which ends with one result per cycle.
// An error run gives its one result in the cycle after its last point; results cannot stall.
// rst_n clears control state and restores register defaults; stores are not cleared.
module velocity_profile_smoother
#(
    parameter int MAX_POINTS_STORED = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] sample_time,
    input  logic signed [31:0] position,
    input  logic signed [31:0] velocity,
    input  logic               last_point,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic         [1:0] cfg_index,
    input  logic        [31:0] cfg_data,
    output logic               result_valid,
    output logic         [5:0] point_index,
    output logic signed [31:0] out_time,
    output logic signed [31:0] out_position,
    output logic signed [31:0] smoothed_velocity,
    output logic         [1:0] status,
    output logic               last_result
);

    localparam int AW = (MAX_POINTS_STORED > 1) ? $clog2(MAX_POINTS_STORED) : 1;
    localparam int CW = $clog2(MAX_POINTS_STORED + 1);

    typedef enum logic [11:0] {
        S_LOAD  = 12'b000000000001,
        S_ERR   = 12'b000000000010,
        S_RDL   = 12'b000000000100,
        S_RDM   = 12'b000000001000,
        S_RDR   = 12'b000000010000,
        S_WAIT  = 12'b000000100000,
        S_OPLD  = 12'b000001000000,
        S_OPFIT = 12'b000010000000,
        S_OPSMO = 12'b000100000000,
        S_WR    = 12'b001000000000,
        S_CHECK = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // Stores
    logic signed [31:0] time_mem [MAX_POINTS_STORED];
    logic signed [31:0] pos_mem  [MAX_POINTS_STORED];
    logic signed [31:0] ref_mem  [MAX_POINTS_STORED];
    logic signed [31:0] vel_mem  [MAX_POINTS_STORED];

    logic        [15:0] wd_reg, ws_reg, maxit_reg;
    logic        [30:0] thr_reg;
    logic      [CW-1:0] count_reg;
    logic signed [31:0] prev_time_reg;
    logic         [1:0] err_reg;
    logic        [31:0] largest_reg;
    logic        [15:0] sweep_reg;
    logic      [AW-1:0] idx_reg;
    logic      [AW-1:0] out_idx_reg;
    logic               rd_pending_reg;
    logic signed [31:0] vl_reg, vm_reg, vr_reg, vref_reg, vrd_reg, rrd_reg;
    logic signed [31:0] trd_reg, prd_reg;
    logic      [AW-1:0] rd_addr;
    logic               accept;
    logic               full;
    logic         [1:0] err_now;
    logic      [CW-1:0] n_now;
    logic        [15:0] limit;
    logic        [30:0] thr;
    logic signed [31:0] new_v;
    logic        [31:0] change;
    logic        [31:0] largest_upd;
    vps_pkg::alu_cmd_t  cmd;
    logic         [1:0] err_status_reg;

    assign busy      = (state_reg != S_LOAD);
    assign cfg_ready = (state_reg == S_LOAD);
    assign accept    = start && !busy;
    assign full      = (count_reg == CW'(MAX_POINTS_STORED));
    assign limit     = (maxit_reg == 16'd0) ? vps_pkg::DEFAULT_SWEEPS : maxit_reg;
    assign thr       = (thr_reg == 31'd0) ? vps_pkg::DEFAULT_THRESHOLD : thr_reg;

    // Error recorded by the accepted point, first error wins
    always_comb
    begin
        err_now = err_reg;
        if (err_reg == vps_pkg::ST_OK)
        begin
            if (count_reg != '0 && sample_time <= prev_time_reg)
            begin
                err_now = vps_pkg::ST_ORDER;
            end
            else if (full)
            begin
                err_now = vps_pkg::ST_OVERFLOW;
            end
        end
        n_now = full ? count_reg : count_reg + CW'(1);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wd_reg    <= 16'd6554;
            ws_reg    <= 16'd13107;
            maxit_reg <= 16'd100;
            thr_reg   <= 31'd655;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vps_pkg::REG_WDATA:   wd_reg    <= cfg_data[15:0];
                vps_pkg::REG_WSMOOTH: ws_reg    <= cfg_data[15:0];
                vps_pkg::REG_MAXIT:   maxit_reg <= cfg_data[15:0];
                vps_pkg::REG_THRESH:  thr_reg   <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read address for each state
    always_comb
    begin
        rd_addr = idx_reg;
        case (state_reg)
            S_RDL:   rd_addr = idx_reg - AW'(1);
            S_RDR:   rd_addr = idx_reg + AW'(1);
            default: rd_addr = idx_reg;
        endcase
    end

    // Store write and registered reads
    always_ff @(posedge clk)
    begin
        if (accept && !full)
        begin
            time_mem[count_reg[AW-1:0]] <= sample_time;
            pos_mem[count_reg[AW-1:0]]  <= position;
            ref_mem[count_reg[AW-1:0]]  <= velocity;
            vel_mem[count_reg[AW-1:0]]  <= velocity;
        end
        else if (state_reg == S_WR)
        begin
            vel_mem[idx_reg] <= new_v;
        end
        vrd_reg <= vel_mem[rd_addr];
        rrd_reg <= ref_mem[rd_addr];
        trd_reg <= time_mem[rd_addr];
        prd_reg <= pos_mem[rd_addr];
    end

    // Operand capture from the read port
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_RDM: vl_reg <= vrd_reg;
            S_RDR: vm_reg <= vrd_reg;
            S_WAIT: vr_reg <= vrd_reg;
            default:
            begin
            end
        endcase
        if (state_reg == S_RDR)
        begin
            vref_reg <= rrd_reg;
        end
    end

    always_comb
    begin
        cmd.en = 1'b1;
        case (state_reg)
            S_OPLD:  cmd.op = vps_pkg::OP_LOAD;
            S_OPFIT: cmd.op = vps_pkg::OP_FIT;
            S_OPSMO: cmd.op = vps_pkg::OP_SMO;
            default:
            begin
                cmd.op = vps_pkg::OP_SUM;
                cmd.en = 1'b0;
            end
        endcase
    end

    vps_alu u_alu
    (
        .clk     (clk),
        .cmd     (cmd),
        .v_left  (vl_reg),
        .v_mid   (vm_reg),
        .v_right (vr_reg),
        .v_ref   (vref_reg),
        .wd      (wd_reg),
        .ws      (ws_reg),
        .new_v   (new_v),
        .change  (change)
    );

    assign largest_upd = (change > largest_reg) ? change : largest_reg;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept && last_point)
                begin
                    if (n_now <= CW'(2) || err_now != vps_pkg::ST_OK)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        state_next = S_RDL;
                    end
                end
            end
            S_ERR:   state_next = S_LOAD;
            S_RDL:   state_next = S_RDM;
            S_RDM:   state_next = S_RDR;
            S_RDR:   state_next = S_WAIT;
            S_WAIT:  state_next = S_OPLD;
            S_OPLD:  state_next = S_OPFIT;
            S_OPFIT: state_next = S_OPSMO;
            S_OPSMO: state_next = S_WR;
            S_WR:
            begin
                if (CW'(idx_reg) + CW'(2) >= count_reg)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_RDL;
                end
            end
            S_CHECK:
            begin
                if (largest_reg < {1'b0, thr} || sweep_reg + 16'd1 >= limit)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RDL;
                end
            end
            S_OUT:
            begin
                if (!rd_pending_reg && CW'(out_idx_reg) + CW'(1) >= count_reg)
                begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            count_reg      <= '0;
            prev_time_reg  <= '0;
            err_reg        <= vps_pkg::ST_OK;
            largest_reg    <= '0;
            sweep_reg      <= '0;
            idx_reg        <= '0;
            rd_pending_reg <= 1'b0;
            err_status_reg <= vps_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        prev_time_reg <= sample_time;
                        count_reg     <= n_now;
                        err_reg       <= err_now;
                        idx_reg       <= AW'(1);
                        largest_reg   <= '0;
                        sweep_reg     <= '0;
                        err_status_reg <= (n_now <= CW'(2)) ? vps_pkg::ST_FEW : err_now;
                    end
                end
                S_ERR:
                begin
                    count_reg     <= '0;
                    prev_time_reg <= '0;
                    err_reg       <= vps_pkg::ST_OK;
                end
                S_WR:
                begin
                    largest_reg <= largest_upd;
                    idx_reg     <= idx_reg + AW'(1);
                end
                S_CHECK:
                begin
                    largest_reg <= '0;
                    sweep_reg   <= sweep_reg + 16'd1;
                    if (state_next == S_OUT)
                    begin
                        idx_reg        <= '0;
                        rd_pending_reg <= 1'b1;
                    end
                    else
                    begin
                        idx_reg <= AW'(1);
                    end
                end
                S_OUT:
                begin
                    // The read address runs one point ahead of the result on the ports
                    rd_pending_reg <= 1'b0;
                    idx_reg        <= idx_reg + AW'(1);
                    if (state_next == S_LOAD)
                    begin
                        count_reg     <= '0;
                        prev_time_reg <= '0;
                        err_reg       <= vps_pkg::ST_OK;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read address advances with idx while the output registers follow one behind
    always_ff @(posedge clk)
    begin
        out_idx_reg <= idx_reg;
    end

    assign result_valid      = (state_reg == S_ERR) ||
                               (state_reg == S_OUT && !rd_pending_reg);
    assign point_index       = (state_reg == S_OUT) ? 6'(out_idx_reg) : 6'd0;
    assign out_time          = (state_reg == S_OUT) ? trd_reg : 32'sd0;
    assign out_position      = (state_reg == S_OUT) ? prd_reg : 32'sd0;
    assign smoothed_velocity = (state_reg == S_OUT) ? vrd_reg : 32'sd0;
    assign status            = (state_reg == S_ERR) ? err_status_reg : vps_pkg::ST_OK;
    assign last_result       = (state_reg == S_ERR) ||
                               (CW'(out_idx_reg) + CW'(1) == count_reg);

    // No input is taken while a run is being smoothed or emitted; the check covers the output state
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> busy)
        else $error("accept possible during output");

    // An error result always ends the run
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERR) |=> (state_reg == S_LOAD))
        else $error("error result did not end run");

    // Point count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS_STORED))
        else $error("point count overflow");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int  DEPTH       = 64;
    localparam int  RANDOM_GOAL = 420;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [31:0] t;
        logic signed [31:0] p;
        logic signed [31:0] v;
        logic               last;
    } point_t;

    typedef struct {
        logic        [5:0]  idx;
        logic signed [31:0] t;
        logic signed [31:0] p;
        logic signed [31:0] v;
        logic        [1:0]  st;
        logic               last;
    } smoothed_point_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] sample_time;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic               last_point;
    logic               cfg_valid;
    logic               cfg_ready;
    logic        [1:0]  cfg_index;
    logic        [31:0] cfg_data;
    logic               result_valid;
    logic        [5:0]  point_index;
    logic signed [31:0] out_time;
    logic signed [31:0] out_position;
    logic signed [31:0] smoothed_velocity;
    logic        [1:0]  status;
    logic               last_result;

    velocity_profile_smoother u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .sample_time       (sample_time),
        .position          (position),
        .velocity          (velocity),
        .last_point        (last_point),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .result_valid      (result_valid),
        .point_index       (point_index),
        .out_time          (out_time),
        .out_position      (out_position),
        .smoothed_velocity (smoothed_velocity),
        .status            (status),
        .last_result       (last_result)
    );

    // Stimulus queue, expected results and scoreboard counters
    point_t          profile_queue[$];
    smoothed_point_t expected_points[$];
    int              error_count;
    int              accepted_count;
    int              random_count;
    longint          cycle_count;
    bit              was_taken;

    // Predictor state
    logic [15:0]        pr_wdata;
    logic [15:0]        pr_wsmooth;
    logic [15:0]        pr_maxit;
    logic [30:0]        pr_thresh;
    logic signed [31:0] pr_time[DEPTH];
    logic signed [31:0] pr_pos[DEPTH];
    logic signed [31:0] pr_ref[DEPTH];
    logic signed [31:0] pr_vel[DEPTH];
    int                 pr_count;
    logic signed [31:0] pr_prev_time;
    logic        [1:0]  pr_error;

    // Clock generation
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Rounds away 16 fraction bits: add half, then floor.
    function automatic longint round_q16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    // One Gauss-Seidel pass over the interior points; returns the largest change.
    function automatic longint smoothing_sweep(input int n);
        longint v, diff, lap, nv, ch, largest;
        largest = 0;
        for (int i = 1; i + 1 < n; i++)
        begin
            v    = pr_vel[i];
            diff = longint'(pr_ref[i]) - v;
            lap  = longint'(pr_vel[i-1]) + longint'(pr_vel[i+1]) - 2 * v;
            nv   = v + round_q16(longint'(pr_wdata) * diff)
                     + round_q16(longint'(pr_wsmooth) * lap);
            if (nv > 64'sd2147483647)
                nv = 64'sd2147483647;
            else if (nv < -64'sd2147483648)
                nv = -64'sd2147483648;
            ch = (nv > v) ? nv - v : v - nv;
            pr_vel[i] = nv[31:0];
            if (ch > largest)
                largest = ch;
        end
        return largest;
    endfunction

    // Takes one accepted point and queues the results that it causes.
    task automatic predict_profile_point(input point_t pt);
        smoothed_point_t r;
        int     limit;
        longint thr;
        if (pr_count > 0 && pt.t <= pr_prev_time && pr_error == vps_pkg::ST_OK)
            pr_error = vps_pkg::ST_ORDER;
        if (pr_count < DEPTH)
        begin
            pr_time[pr_count] = pt.t;
            pr_pos[pr_count]  = pt.p;
            pr_ref[pr_count]  = pt.v;
            pr_vel[pr_count]  = pt.v;
            pr_count++;
        end
        else if (pr_error == vps_pkg::ST_OK)
            pr_error = vps_pkg::ST_OVERFLOW;
        pr_prev_time = pt.t;
        if (!pt.last)
            return;

        if (pr_count <= 2 || pr_error != vps_pkg::ST_OK)
        begin
            r = '{idx: '0, t: '0, p: '0, v: '0, st: vps_pkg::ST_OK, last: 1'b1};
            r.st = (pr_count <= 2) ? vps_pkg::ST_FEW : pr_error;
            expected_points.push_back(r);
        end
        else
        begin
            limit = (pr_maxit == 0) ? int'(vps_pkg::DEFAULT_SWEEPS) : int'(pr_maxit);
            thr   = (pr_thresh == 0) ? longint'(vps_pkg::DEFAULT_THRESHOLD)
                                     : longint'(pr_thresh);
            for (int s = 0; s < limit; s++)
            begin
                if (smoothing_sweep(pr_count) < thr)
                    break;
            end
            for (int k = 0; k < pr_count; k++)
            begin
                r.idx  = k[5:0];
                r.t    = pr_time[k];
                r.p    = pr_pos[k];
                r.v    = pr_vel[k];
                r.st   = vps_pkg::ST_OK;
                r.last = (k + 1 == pr_count);
                expected_points.push_back(r);
            end
        end
        pr_count     = 0;
        pr_prev_time = '0;
        pr_error     = vps_pkg::ST_OK;
    endtask

    // Acceptance of a point at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            predict_profile_point('{t: sample_time, p: position, v: velocity,
                                    last: last_point});
            void'(profile_queue.pop_front());
            accepted_count++;
            was_taken = 1'b1;
        end
    end

    // Point driver: changes inputs at the falling edge
    always @(negedge clk)
    begin
        int idle_pct;
        idle_pct = (accepted_count < 140) ? 14 : (accepted_count < 280) ? 68 : 0;
        if (!rst_n)
            start <= 1'b0;
        else if (start && !was_taken)
            start <= 1'b1;
        else if (profile_queue.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            start       <= 1'b1;
            sample_time <= profile_queue[0].t;
            position    <= profile_queue[0].p;
            velocity    <= profile_queue[0].v;
            last_point  <= profile_queue[0].last;
        end
        else
            start <= 1'b0;
        was_taken = 1'b0;
    end

    // Result monitor
    always @(posedge clk)
    begin
        smoothed_point_t w;
        if (rst_n && result_valid)
        begin
            if (expected_points.size() == 0)
                report_mismatch("unexpected result, point_index", point_index, -1);
            else
            begin
                w = expected_points.pop_front();
                if (point_index !== w.idx)
                    report_mismatch("point_index", point_index, w.idx);
                if (out_time !== w.t)
                    report_mismatch("out_time", out_time, w.t);
                if (out_position !== w.p)
                    report_mismatch("out_position", out_position, w.p);
                if (smoothed_velocity !== w.v)
                    report_mismatch("smoothed_velocity", smoothed_velocity, w.v);
                if (status !== w.st)
                    report_mismatch("status", status, w.st);
                if (last_result !== w.last)
                    report_mismatch("last_result", last_result, w.last);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Writes one register over the configuration channel.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            vps_pkg::REG_WDATA:   pr_wdata   = data[15:0];
            vps_pkg::REG_WSMOOTH: pr_wsmooth = data[15:0];
            vps_pkg::REG_MAXIT:   pr_maxit   = data[15:0];
            default:              pr_thresh  = data[30:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_settings(input logic [15:0] wd, input logic [15:0] ws,
                                  input logic [15:0] mi, input logic [30:0] th);
        write_register(vps_pkg::REG_WDATA, {16'd0, wd});
        write_register(vps_pkg::REG_WSMOOTH, {16'd0, ws});
        write_register(vps_pkg::REG_MAXIT, {16'd0, mi});
        write_register(vps_pkg::REG_THRESH, {1'b0, th});
    endtask

    // Waits for every queued point to go in and every result to come out.
    task automatic wait_drained();
        wait (profile_queue.size() == 0 && expected_points.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [31:0] random_velocity();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(1, 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(20 << 16)) - (10 << 16);
        endcase
    endfunction

    // Queues a run of n points; an order fault repeats a time stamp or steps back.
    task automatic add_run(input int n, input bit order_fault);
        point_t pt;
        longint tm;
        int     bad;
        tm  = $urandom_range(1, 0) ? longint'($signed($urandom)) : $urandom_range(1000);
        if (tm > 64'sd2147483647 - 64'sd200000000)
            tm = 64'sd2147483647 - 64'sd200000000;
        bad = order_fault ? $urandom_range(n - 1, 1) : -1;
        for (int k = 0; k < n; k++)
        begin
            if (k == bad)
                tm = tm - $urandom_range(2, 0);
            else if (k > 0)
                tm = tm + $urandom_range(1 << 20, 1);
            pt.t    = tm[31:0];
            pt.p    = $urandom;
            pt.v    = random_velocity();
            pt.last = (k == n - 1);
            profile_queue.push_back(pt);
        end
        random_count += n;
    endtask

    // Queues a random mix of runs, mostly short and well formed.
    task automatic add_random_runs(input int items);
        int goal;
        int sel;
        goal = random_count + items;
        while (random_count < goal)
        begin
            sel = $urandom_range(99);
            if (sel < 5)
                add_run($urandom_range(2, 1), $urandom_range(1, 0));
            else if (sel < 18)
                add_run($urandom_range(8, 3), 1'b1);
            else if (sel < 21)
                add_run($urandom_range(70, 65), $urandom_range(3, 0) == 0);
            else if (sel < 27)
                add_run($urandom_range(64, 13), 1'b0);
            else
                add_run($urandom_range(10, 3), 1'b0);
        end
    endtask

    initial
    begin
        point_t pt;
        start        = 1'b0;
        sample_time  = '0;
        position     = '0;
        velocity     = '0;
        last_point   = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = vps_pkg::REG_WDATA;
        cfg_data     = '0;
        error_count  = 0;
        accepted_count = 0;
        random_count = 0;
        cycle_count  = 0;
        was_taken    = 1'b0;
        pr_wdata     = 16'd6554;
        pr_wsmooth   = 16'd13107;
        pr_maxit     = vps_pkg::DEFAULT_SWEEPS;
        pr_thresh    = vps_pkg::DEFAULT_THRESHOLD;
        pr_count     = 0;
        pr_prev_time = '0;
        pr_error     = vps_pkg::ST_OK;
        rst_n        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under reset settings: extremes, short runs and order faults.
        pt = '{t: 32'sh8000_0000, p: 32'sh8000_0000, v: 32'sh7FFF_FFFF, last: 1'b0};
        profile_queue.push_back(pt);
        pt = '{t: 32'sh0000_0000, p: 32'sh7FFF_FFFF, v: 32'sh8000_0000, last: 1'b0};
        profile_queue.push_back(pt);
        pt = '{t: 32'sh7FFF_FFFF, p: 32'sh0000_0000, v: 32'sh7FFF_FFFF, last: 1'b1};
        profile_queue.push_back(pt);
        pt = '{t: 32'sh0000_0010, p: 32'sh1234_5678, v: 32'sh0001_0000, last: 1'b1};
        profile_queue.push_back(pt);
        pt = '{t: 32'sh0000_0010, p: 32'sh0, v: 32'sh0, last: 1'b0};
        profile_queue.push_back(pt);
        pt = '{t: 32'sh0000_0010, p: 32'sh0, v: 32'sh0, last: 1'b1};
        profile_queue.push_back(pt);
        pt = '{t: 32'sh0000_0100, p: 32'sh0, v: 32'sh0001_0000, last: 1'b0};
        profile_queue.push_back(pt);
        pt = '{t: 32'sh0000_0100, p: 32'sh0, v: 32'sh0002_0000, last: 1'b0};
        profile_queue.push_back(pt);
        pt = '{t: 32'sh0000_0200, p: 32'sh0, v: 32'sh0003_0000, last: 1'b1};
        profile_queue.push_back(pt);
        add_run(5, 1'b0);
        add_run(4, 1'b1);
        random_count = 0;
        wait_drained();

        // Zero weights leave the points unchanged; zero sweep limit and zero threshold select the defaults.
        write_settings(16'd0, 16'd0, 16'd0, 31'd0);
        add_run(6, 1'b0);
        add_random_runs(40);
        wait_drained();

        // Full weights, a single sweep and the smallest threshold.
        write_settings(16'hFFFF, 16'hFFFF, 16'd1, 31'd1);
        add_random_runs(60);
        wait_drained();

        // Largest sweep limit, held back by the largest threshold.
        write_settings(16'hFFFF, 16'd0, 16'hFFFF, 31'h7FFF_FFFF);
        add_random_runs(50);
        wait_drained();

        // Default settings restored, then random moderate settings.
        write_settings(16'd6554, 16'd13107, vps_pkg::DEFAULT_SWEEPS,
                       vps_pkg::DEFAULT_THRESHOLD);
        add_random_runs(70);
        wait_drained();
        while (random_count < RANDOM_GOAL)
        begin
            write_settings($urandom_range(20000), $urandom_range(30000),
                           $urandom_range(150, 1), $urandom_range(100000, 1));
            add_random_runs(50);
            wait_drained();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
